// ===== hdl/ism_pkg.sv =====
package ism_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 64;
  localparam int unsigned DIST_WIDTH_DEF    = 32;

  // merge tolerance register width, and the width a gap is compared at
  localparam int unsigned TOL_W = 31;
  localparam int unsigned GAP_W = 33;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_FIRST,
    ST_SWEEP
  } ism_state_e;

endpackage

// ===== hdl/ism_cell.sv =====
module ism_cell #(
  parameter int unsigned DIST_WIDTH = ism_pkg::DIST_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_i,
  // word traveling in from the left neighbor
  input  logic                         in_valid_i,
  input  logic signed [DIST_WIDTH-1:0] in_lo_i,
  input  logic signed [DIST_WIDTH-1:0] in_hi_i,
  // right neighbor's held word, taken on a pop
  input  logic                         nb_valid_i,
  input  logic signed [DIST_WIDTH-1:0] nb_lo_i,
  input  logic signed [DIST_WIDTH-1:0] nb_hi_i,
  // word handed on to the right
  output logic                         pass_valid_o,
  output logic signed [DIST_WIDTH-1:0] pass_lo_o,
  output logic signed [DIST_WIDTH-1:0] pass_hi_o,
  // held word
  output logic                         valid_o,
  output logic signed [DIST_WIDTH-1:0] lo_o,
  output logic signed [DIST_WIDTH-1:0] hi_o
);

  logic                         valid_q, valid_d;
  logic signed [DIST_WIDTH-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                         pass_valid_q, pass_valid_d;
  logic signed [DIST_WIDTH-1:0] pass_lo_q, pass_lo_d, pass_hi_q, pass_hi_d;

  always_comb begin
    valid_d      = valid_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pass_valid_d = 1'b0;
    pass_lo_d    = pass_lo_q;
    pass_hi_d    = pass_hi_q;
    if (pop_i) begin
      valid_d = nb_valid_i;
      lo_d    = nb_lo_i;
      hi_d    = nb_hi_i;
    end else if (in_valid_i) begin
      if (!valid_q) begin
        valid_d = 1'b1;
        lo_d    = in_lo_i;
        hi_d    = in_hi_i;
      end else if (in_lo_i < lo_q) begin
        // keep the smaller start, push the held word on
        lo_d         = in_lo_i;
        hi_d         = in_hi_i;
        pass_valid_d = 1'b1;
        pass_lo_d    = lo_q;
        pass_hi_d    = hi_q;
      end else begin
        pass_valid_d = 1'b1;
        pass_lo_d    = in_lo_i;
        pass_hi_d    = in_hi_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      pass_valid_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      pass_valid_q <= pass_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    pass_lo_q <= pass_lo_d;
    pass_hi_q <= pass_hi_d;
  end

  assign pass_valid_o = pass_valid_q;
  assign pass_lo_o    = pass_lo_q;
  assign pass_hi_o    = pass_hi_q;
  assign valid_o      = valid_q;
  assign lo_o         = lo_q;
  assign hi_o         = hi_q;

endmodule

// ===== hdl/ism_merge.sv =====
module ism_merge #(
  parameter int unsigned MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned DIST_WIDTH    = ism_pkg::DIST_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            final_interval_i,
  output logic                            store_o,
  input  logic                            busy_i,
  output logic                            pop_o,
  input  logic signed [DIST_WIDTH-1:0]    head_lo_i,
  input  logic signed [DIST_WIDTH-1:0]    head_hi_i,
  input  logic [ism_pkg::TOL_W-1:0]       tol_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [DIST_WIDTH-1:0]    segment_start_o,
  output logic signed [DIST_WIDTH-1:0]    segment_end_o,
  output logic                            last_segment_o,
  output logic                            overflowed_o
);

  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned EXT_W = ism_pkg::GAP_W - DIST_WIDTH;

  ism_pkg::ism_state_e state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d, rem_q, rem_d;
  logic                ovf_q, ovf_d;
  logic signed [DIST_WIDTH-1:0] cs_q, cs_d, ce_q, ce_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [DIST_WIDTH-1:0] out_start_q, out_start_d, out_end_q, out_end_d;
  logic                         out_last_q, out_last_d, out_ovf_q, out_ovf_d;

  logic                           out_free;
  logic                           accept;
  logic signed [ism_pkg::GAP_W-1:0] gap, tol_ext;
  logic                           joins;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && (state_q == ism_pkg::ST_LOAD);
  assign gap      = $signed({{EXT_W{head_lo_i[DIST_WIDTH-1]}}, head_lo_i})
                  - $signed({{EXT_W{ce_q[DIST_WIDTH-1]}}, ce_q});
  assign tol_ext  = $signed({{(ism_pkg::GAP_W - ism_pkg::TOL_W){1'b0}}, tol_i});
  assign joins    = gap <= tol_ext;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    ovf_d       = ovf_q;
    cs_d        = cs_q;
    ce_d        = ce_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    in_ready_o  = 1'b0;
    store_o     = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      ism_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        store_o    = accept && (count_q < CNT_W'(MAX_INTERVALS));
        if (accept) begin
          if (store_o) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (final_interval_i) begin
            state_d = ism_pkg::ST_SETTLE;
          end
        end
      end
      ism_pkg::ST_SETTLE: begin
        if (!busy_i) begin
          state_d = ism_pkg::ST_FIRST;
        end
      end
      ism_pkg::ST_FIRST: begin
        pop_o   = 1'b1;
        cs_d    = head_lo_i;
        ce_d    = head_hi_i;
        rem_d   = count_q - CNT_W'(1);
        state_d = ism_pkg::ST_SWEEP;
      end
      ism_pkg::ST_SWEEP: begin
        if (rem_q != '0) begin
          if (joins) begin
            pop_o = 1'b1;
            rem_d = rem_q - CNT_W'(1);
            if (head_hi_i > ce_q) begin
              ce_d = head_hi_i;
            end
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_start_d = cs_q;
            out_end_d   = ce_q;
            out_last_d  = 1'b0;
            out_ovf_d   = ovf_q;
            pop_o       = 1'b1;
            rem_d       = rem_q - CNT_W'(1);
            cs_d        = head_lo_i;
            ce_d        = head_hi_i;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_start_d = cs_q;
          out_end_d   = ce_q;
          out_last_d  = 1'b1;
          out_ovf_d   = ovf_q;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ism_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = ism_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ism_pkg::ST_LOAD;
      count_q     <= '0;
      rem_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q        <= cs_d;
    ce_q        <= ce_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign segment_start_o = out_start_q;
  assign segment_end_o   = out_end_q;
  assign last_segment_o  = out_last_q;
  assign overflowed_o    = out_ovf_q;

endmodule

// ===== hdl/interval_sort_merge.sv =====
// Channel   | Handshake                  | Word
// ----------+----------------------------+---------------------------------------------
// in        | in_valid_i / in_ready_o    | entry_distance_i, exit_distance_i,
//           |                            | final_interval_i
// out       | out_valid_o / out_ready_i  | segment_start_o, segment_end_o,
//           |                            | last_segment_o, overflowed_o
// config    | merge_tolerance_we_i       | merge_tolerance_i (no wait, no read-back)
//
// Intervals load one word per cycle into a chain of MAX_INTERVALS sort cells.
// After the final word of a set, in_ready_o drops; the chain settles (the last inserted
// word ripples right one cell per cycle), then the sweep pops the chain head. Unstalled,
// the last segment shows on out in the same cycle that in_ready_o rises. A stall on out
// holds the sweep only when a segment is due to leave. Reset empties the chain, count,
// flag and tolerance.
module interval_sort_merge #(
  parameter int unsigned MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned DIST_WIDTH    = ism_pkg::DIST_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         merge_tolerance_we_i,
  input  logic [ism_pkg::TOL_W-1:0]    merge_tolerance_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DIST_WIDTH-1:0] entry_distance_i,
  input  logic signed [DIST_WIDTH-1:0] exit_distance_i,
  input  logic                         final_interval_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DIST_WIDTH-1:0] segment_start_o,
  output logic signed [DIST_WIDTH-1:0] segment_end_o,
  output logic                         last_segment_o,
  output logic                         overflowed_o
);

  logic [ism_pkg::TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (merge_tolerance_we_i) begin
      tol_q <= merge_tolerance_i;
    end
  end

  // order the two ends so the smaller one is the start
  logic                         swap;
  logic signed [DIST_WIDTH-1:0] new_lo, new_hi;
  logic                         store;

  assign swap   = entry_distance_i > exit_distance_i;
  assign new_lo = swap ? exit_distance_i : entry_distance_i;
  assign new_hi = swap ? entry_distance_i : exit_distance_i;

  // sort chain: cell 0 holds the smallest start
  logic                         pop;
  logic [MAX_INTERVALS-1:0]     pass_v, cell_v;
  logic signed [DIST_WIDTH-1:0] pass_lo [MAX_INTERVALS];
  logic signed [DIST_WIDTH-1:0] pass_hi [MAX_INTERVALS];
  logic signed [DIST_WIDTH-1:0] cell_lo [MAX_INTERVALS];
  logic signed [DIST_WIDTH-1:0] cell_hi [MAX_INTERVALS];

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    logic                         lin_v, nb_v;
    logic signed [DIST_WIDTH-1:0] lin_lo, lin_hi, nb_lo, nb_hi;

    if (k == 0) begin : g_head
      assign lin_v  = store;
      assign lin_lo = new_lo;
      assign lin_hi = new_hi;
    end else begin : g_body
      assign lin_v  = pass_v[k-1];
      assign lin_lo = pass_lo[k-1];
      assign lin_hi = pass_hi[k-1];
    end

    if (k == MAX_INTERVALS - 1) begin : g_tail
      // shift an empty word in at the far end
      assign nb_v  = 1'b0;
      assign nb_lo = '0;
      assign nb_hi = '0;
    end else begin : g_next
      assign nb_v  = cell_v[k+1];
      assign nb_lo = cell_lo[k+1];
      assign nb_hi = cell_hi[k+1];
    end

    ism_cell #(
      .DIST_WIDTH(DIST_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .pop_i       (pop),
      .in_valid_i  (lin_v),
      .in_lo_i     (lin_lo),
      .in_hi_i     (lin_hi),
      .nb_valid_i  (nb_v),
      .nb_lo_i     (nb_lo),
      .nb_hi_i     (nb_hi),
      .pass_valid_o(pass_v[k]),
      .pass_lo_o   (pass_lo[k]),
      .pass_hi_o   (pass_hi[k]),
      .valid_o     (cell_v[k]),
      .lo_o        (cell_lo[k]),
      .hi_o        (cell_hi[k])
    );
  end

  // sweep over the sorted chain, merge, and drive the output register
  ism_merge #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .DIST_WIDTH   (DIST_WIDTH)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .final_interval_i(final_interval_i),
    .store_o         (store),
    .busy_i          (|pass_v),
    .pop_o           (pop),
    .head_lo_i       (cell_lo[0]),
    .head_hi_i       (cell_hi[0]),
    .tol_i           (tol_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .segment_start_o (segment_start_o),
    .segment_end_o   (segment_end_o),
    .last_segment_o  (last_segment_o),
    .overflowed_o    (overflowed_o)
  );

endmodule

// ===== tb/tb_interval_sort_merge.sv =====
`timescale 1ns / 1ps

module tb_interval_sort_merge;

  localparam int MAXN = ism_pkg::MAX_INTERVALS_DEF;
  localparam int DW   = ism_pkg::DIST_WIDTH_DEF;

  localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] ONE   = 32'sh0001_0000;  // 1.0 in Q16.16

  localparam logic [ism_pkg::TOL_W-1:0] TOL_MAX = '1;

  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 2 * MAXN + 60;
  localparam int N_DIRECTED   = 19;

  // one merged segment as it leaves the block
  typedef struct packed {
    logic signed [DW-1:0] seg_start;
    logic signed [DW-1:0] seg_end;
    logic                 last;
    logic                 ovf;
  } segment_t;

  // one input word plus, for single-segment sets, the segment it must produce
  typedef struct packed {
    logic signed [DW-1:0] entry;
    logic signed [DW-1:0] exitd;
    logic                 fin;
    logic                 typed;
    logic signed [DW-1:0] want_start;
    logic signed [DW-1:0] want_end;
  } word_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         merge_tolerance_we_i = 1'b0;
  logic [ism_pkg::TOL_W-1:0]    merge_tolerance_i    = '0;
  logic                         in_valid_i           = 1'b0;
  logic                         in_ready_o;
  logic signed [DW-1:0]         entry_distance_i     = '0;
  logic signed [DW-1:0]         exit_distance_i      = '0;
  logic                         final_interval_i     = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i          = 1'b0;
  logic signed [DW-1:0]         segment_start_o;
  logic signed [DW-1:0]         segment_end_o;
  logic                         last_segment_o;
  logic                         overflowed_o;

  // idle odds per cycle, in percent, for each side
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req     = 1'b0;

  // shadow of the block: held intervals, overflow flag, tolerance
  longint      held_lo [MAXN];
  longint      held_hi [MAXN];
  int          held_count = 0;
  bit          held_over  = 1'b0;
  int unsigned merge_tol  = 0;

  segment_t  due_segments[$];    // segments still to come out, oldest first
  segment_t  fresh_segments[$];  // segments of the set just closed
  word_row_t offered_rows[$];    // words driven but not yet taken

  int mismatch_count = 0;

  int          cluster_base   = 0;
  int          cluster_spread = 16;

  word_row_t directed_rows [N_DIRECTED] = '{
    // lone intervals: the segment is the ordered pair itself
    '{D_MIN, D_MAX, 1'b1, 1'b1, D_MIN, D_MAX},
    '{D_MAX, D_MIN, 1'b1, 1'b1, D_MIN, D_MAX},
    '{5 * ONE, -3 * ONE, 1'b1, 1'b1, -3 * ONE, 5 * ONE},
    '{'0, '0, 1'b1, 1'b1, '0, '0},
    '{-1, -1, 1'b1, 1'b1, -1, -1},
    // touching, swapped, equal starts, overlap, a one-unit gap
    '{30 * ONE, 40 * ONE, 1'b0, 1'b0, '0, '0},
    '{10 * ONE, 20 * ONE, 1'b0, 1'b0, '0, '0},
    '{25 * ONE, 20 * ONE, 1'b0, 1'b0, '0, '0},
    '{10 * ONE, 12 * ONE, 1'b0, 1'b0, '0, '0},
    '{35 * ONE, 50 * ONE, 1'b0, 1'b0, '0, '0},
    '{51 * ONE, 60 * ONE, 1'b0, 1'b0, '0, '0},
    '{D_MAX, D_MAX, 1'b1, 1'b0, '0, '0},
    // one interval spanning the whole range swallows both extremes
    '{D_MIN, D_MIN, 1'b0, 1'b0, '0, '0},
    '{D_MAX, D_MIN, 1'b0, 1'b0, '0, '0},
    '{D_MAX, D_MAX, 1'b1, 1'b0, '0, '0},
    // both extremes around two short intervals, then a gap of one unit
    '{D_MIN, D_MIN, 1'b0, 1'b0, '0, '0},
    '{D_MAX, D_MAX, 1'b0, 1'b0, '0, '0},
    '{'0, 1, 1'b0, 1'b0, '0, '0},
    '{2, 3, 1'b1, 1'b0, '0, '0}
  };

  interval_sort_merge dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .merge_tolerance_we_i (merge_tolerance_we_i),
    .merge_tolerance_i    (merge_tolerance_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .entry_distance_i     (entry_distance_i),
    .exit_distance_i      (exit_distance_i),
    .final_interval_i     (final_interval_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .segment_start_o      (segment_start_o),
    .segment_end_o        (segment_end_o),
    .last_segment_o       (last_segment_o),
    .overflowed_o         (overflowed_o)
  );

  always #6 clk_i = ~clk_i;

  // Hold one interval, or drop it when full. On the final word, sort the held
  // intervals by start, sweep them into merged segments and clear the store.
  function automatic void absorb_interval(input logic signed [DW-1:0] a,
                                          input logic signed [DW-1:0] b,
                                          input logic fin);
    longint   lo [MAXN];
    longint   hi [MAXN];
    longint   key_lo, key_hi, run_lo, run_hi;
    int       i, j;
    segment_t seg;
    if (held_count < MAXN) begin
      held_lo[held_count] = (a <= b) ? a : b;
      held_hi[held_count] = (a <= b) ? b : a;
      held_count++;
    end else begin
      held_over = 1'b1;
    end
    if (!fin) return;
    for (i = 0; i < held_count; i++) begin
      lo[i] = held_lo[i];
      hi[i] = held_hi[i];
    end
    // insertion sort by start
    for (i = 1; i < held_count; i++) begin
      key_lo = lo[i];
      key_hi = hi[i];
      j = i;
      while (j > 0 && lo[j-1] > key_lo) begin
        lo[j] = lo[j-1];
        hi[j] = hi[j-1];
        j--;
      end
      lo[j] = key_lo;
      hi[j] = key_hi;
    end
    run_lo = lo[0];
    run_hi = hi[0];
    for (i = 1; i < held_count; i++) begin
      // gap at 64 bits: overlap gives a negative gap and always merges
      if (lo[i] - run_hi <= longint'(merge_tol)) begin
        if (hi[i] > run_hi) run_hi = hi[i];
      end else begin
        seg.seg_start = run_lo[DW-1:0];
        seg.seg_end   = run_hi[DW-1:0];
        seg.last      = 1'b0;
        seg.ovf       = held_over;
        fresh_segments = {fresh_segments, seg};
        run_lo = lo[i];
        run_hi = hi[i];
      end
    end
    seg.seg_start = run_lo[DW-1:0];
    seg.seg_end   = run_hi[DW-1:0];
    seg.last      = 1'b1;
    seg.ovf       = held_over;
    fresh_segments = {fresh_segments, seg};
    held_count = 0;
    held_over  = 1'b0;
  endfunction

  // Track every accepted input word; queue up the segments it closes.
  always @(posedge clk_i) begin : take_word
    word_row_t row;
    segment_t  seg;
    if (rst_ni && in_valid_i && in_ready_o) begin
      row = offered_rows.pop_front();
      absorb_interval(entry_distance_i, exit_distance_i, final_interval_i);
      if (row.typed && final_interval_i) begin
        // lone interval: use the segment typed into the table
        seg.seg_start = row.want_start;
        seg.seg_end   = row.want_end;
        seg.last      = 1'b1;
        seg.ovf       = 1'b0;
        due_segments = {due_segments, seg};
      end else begin
        due_segments = {due_segments, fresh_segments};
      end
      fresh_segments.delete();
    end
  end

  // Compare every segment that leaves against the oldest one due.
  always @(posedge clk_i) begin : check_segment
    segment_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_segments.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no segment, actual start %0d end %0d last %0b ovf %0b",
                 $time, segment_start_o, segment_end_o, last_segment_o, overflowed_o);
      end else begin
        want = due_segments.pop_front();
        if (segment_start_o !== want.seg_start || segment_end_o !== want.seg_end ||
            last_segment_o !== want.last || overflowed_o !== want.ovf) begin
          mismatch_count++;
          $display("%0t: segment mismatch: expected start %0d end %0d last %0b ovf %0b",
                   $time, want.seg_start, want.seg_end, want.last, want.ovf);
          $display("%0t:                     actual start %0d end %0d last %0b ovf %0b",
                   $time, segment_start_o, segment_end_o, last_segment_o, overflowed_o);
        end
      end
    end
  end

  // Receiver: stall at random; on request, hold off for a long stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one word, idling first at random; return at the edge that takes it.
  task automatic send_word(input word_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    entry_distance_i <= row.entry;
    exit_distance_i  <= row.exitd;
    final_interval_i <= row.fin;
    offered_rows = {offered_rows, row};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait until every due segment is out, then let the sweep finish.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_segments.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the tolerance while the block is idle; mirror it in the shadow.
  task automatic set_tolerance(input logic [ism_pkg::TOL_W-1:0] value);
    merge_tolerance_we_i <= 1'b1;
    merge_tolerance_i    <= value;
    merge_tol             = value;
    @(posedge clk_i);
    merge_tolerance_we_i <= 1'b0;
  endtask

  // Mostly cluster around a per-set base so neighbors merge; now and then
  // use a full-range value or an extreme.
  function automatic logic signed [DW-1:0] pick_distance();
    int off;
    case ($urandom_range(7))
      0: return $urandom();
      1: begin
        case ($urandom_range(3))
          0:       return D_MIN;
          1:       return D_MAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: begin
        off = int'($urandom_range(0, 2 * cluster_spread)) - cluster_spread;
        return cluster_base + off;
      end
    endcase
  endfunction

  task automatic send_set(input int count);
    word_row_t row;
    cluster_base   = $urandom();
    cluster_spread = 1 << $urandom_range(4, 24);
    for (int k = 0; k < count; k++) begin
      row       = '0;
      row.entry = pick_distance();
      row.exitd = pick_distance();
      row.fin   = (k == count - 1);
      send_word(row);
    end
  endtask

  // Random sets: mostly small, some medium, a few near or past capacity.
  task automatic send_random_sets(input int word_target);
    int sent;
    int count;
    int pick;
    sent = 0;
    while (sent < word_target) begin
      pick = $urandom_range(99);
      if (pick < 70)      count = $urandom_range(1, 6);
      else if (pick < 95) count = $urandom_range(7, 24);
      else                count = $urandom_range(MAXN - 4, MAXN + 6);
      send_set(count);
      sent += count;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at zero tolerance, with the first idling mix.
    src_idle_pct = 37;
    snk_idle_pct = 77;
    set_tolerance('0);
    foreach (directed_rows[r]) send_word(directed_rows[r]);
    drain_block();

    // Phase 1: moderate tolerance, sender lightly idle, receiver mostly stalled.
    set_tolerance((ism_pkg::TOL_W)'($urandom_range(1 << 10, 1 << 22)));
    send_random_sets(75);
    drain_block();

    // Phase 2: widest tolerance, idling swapped.
    src_idle_pct = 77;
    snk_idle_pct = 37;
    set_tolerance(TOL_MAX);
    send_random_sets(75);
    drain_block();

    // Phase 3: no idling. Hold the receiver off first while an overfull set
    // and the next set are offered, so the block backs up into its input.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_tolerance((ism_pkg::TOL_W)'($urandom_range(0, 1 << 20)));
    hold_req = 1'b1;
    send_set(MAXN + 6);
    send_set(5);
    send_random_sets(50);
    drain_block();

    if (mismatch_count == 0 && due_segments.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== interval_sort_merge.f =====
hdl/ism_pkg.sv
hdl/ism_cell.sv
hdl/ism_merge.sv
hdl/interval_sort_merge.sv
tb/tb_interval_sort_merge.sv
